[design/lnem_pkg.sv]
// Shared types and constants for the luma neighbourhood edge map.
// Used by every module of the block; depends on nothing else.
package lnem_pkg;

  // Field widths of the pixel stream and results.
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned COL_W  = 10;

  // Configuration register widths and port shape.
  localparam int unsigned THR_W   = 8;
  localparam int unsigned LW_W    = 11;
  localparam int unsigned FR_W    = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Line store geometry.
  localparam int unsigned MAX_LINE  = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_LINE);
  localparam int unsigned MIN_LINE  = 3;
  localparam int unsigned MIN_ROWS  = 3;
  localparam int unsigned MAX_ROWS  = 4096;

  // Gray conversion: floor(sum / 100) as (sum * 5243) >> 19, exact for sum < 43690.
  localparam int unsigned SUM_W      = 15;
  localparam int unsigned RECIP_W    = 13;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam int unsigned GRAY_RECIP = 5243;
  localparam int unsigned GRAY_SHIFT = 19;
  localparam int unsigned W_RED      = 30;
  localparam int unsigned W_GREEN    = 59;
  localparam int unsigned W_BLUE     = 11;

  // Output skid queue.
  localparam int unsigned SKID_DEPTH = 4;
  localparam int unsigned SKID_PTR_W = $clog2(SKID_DEPTH);
  localparam int unsigned SKID_CNT_W = $clog2(SKID_DEPTH + 1);

  // Reset values of the registers.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);
  localparam logic [LW_W-1:0]  LW_RESET  = LW_W'(1024);
  localparam logic [FR_W-1:0]  FR_RESET  = FR_W'(768);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_LINE_WIDTH = 2'd1,
    REG_FRAME_ROWS = 2'd2
  } cfg_reg_t;

  // Position information that travels with a request down the pipeline.
  typedef struct packed {
    logic             has_result;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             last_of_frame;
  } pos_t;

  // One finished result.
  typedef struct packed {
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             is_edge;
    logic             last_of_frame;
  } result_t;

endpackage

[design/lnem_window.sv]
// 3x3 gray window and the threshold compare stage of the edge map.
// Depends on lnem_pkg.
module lnem_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [lnem_pkg::PIX_W-1:0] col_top,
  input  logic [lnem_pkg::PIX_W-1:0] col_mid,
  input  logic [lnem_pkg::PIX_W-1:0] col_bot,
  input  lnem_pkg::pos_t             pos_in,
  input  logic [lnem_pkg::THR_W-1:0] threshold,
  output logic                       busy,
  output logic                       push,
  output lnem_pkg::result_t          result
);
  import lnem_pkg::*;

  logic [PIX_W-1:0] win_r [3][3];
  logic             s2_v_r;
  pos_t             s2_pos_r;
  logic [PIX_W-1:0] center;
  logic             edge_hit;

  // Shift the window left and load the new column, oldest row on top.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= col_top;
      win_r[1][2] <= col_mid;
      win_r[2][2] <= col_bot;
      s2_pos_r    <= pos_in;
    end
  end

  // Stage valid is registered from the shift enable, so it follows the shift in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= shift_en;
    end
  end

  // Any of the eight neighbours further than the threshold marks an edge.
  assign center = win_r[1][1];
  always_comb begin
    logic [PIX_W-1:0] diff;
    edge_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        diff = (center > win_r[i][j]) ? center - win_r[i][j] : win_r[i][j] - center;
        if (!(i == 1 && j == 1) && (diff > threshold)) begin
          edge_hit = 1'b1;
        end
      end
    end
  end

  assign busy = s2_v_r;
  assign push = s2_v_r & s2_pos_r.has_result;
  assign result.center_row    = s2_pos_r.center_row;
  assign result.center_col    = s2_pos_r.center_col;
  assign result.is_edge       = edge_hit;
  assign result.last_of_frame = s2_pos_r.last_of_frame;

endmodule

[design/lnem_skid.sv]
// Small result queue that decouples the pipeline from output stalls.
// Depends on lnem_pkg.
module lnem_skid (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  lnem_pkg::result_t               push_data,
  input  logic                            pop_stall,
  output logic                            pop_valid,
  output lnem_pkg::result_t               pop_data,
  output logic [lnem_pkg::SKID_CNT_W-1:0] count
);
  import lnem_pkg::*;

  result_t               slot_r [SKID_DEPTH];
  logic [SKID_PTR_W-1:0] wr_ptr_r;
  logic [SKID_PTR_W-1:0] rd_ptr_r;
  logic [SKID_CNT_W-1:0] count_r;
  logic                  pop;

  assign pop       = (count_r != '0) & ~pop_stall;
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + SKID_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + SKID_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + SKID_CNT_W'(1);
        2'b01:   count_r <= count_r - SKID_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/luma_neighbourhood_edge_map.sv]
// Threshold edge detector over a 3x3 gray window, RGB raster pixels in.
// The request completing a window passes the first and window stages; its result is then queued.
// Throughput: one pixel per cycle unless in_stall; the line store is read in the accept cycle and
// written back in the next; the same column is requested again at least MIN_LINE requests later.
// Reset (rst_n low, synchronous): counters, pipeline and result queue clear, registers take
// their defaults; the line store has no clearing pass and is undefined until written.
module luma_neighbourhood_edge_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lnem_pkg::PIX_W-1:0]      in_red,
  input  logic [lnem_pkg::PIX_W-1:0]      in_green,
  input  logic [lnem_pkg::PIX_W-1:0]      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lnem_pkg::ROW_W-1:0]      out_center_row,
  output logic [lnem_pkg::COL_W-1:0]      out_center_col,
  output logic                            out_is_edge,
  output logic                            out_last_of_frame,
  input  logic                            cfg_wr_en,
  input  logic [lnem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lnem_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lnem_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic [LW_W-1:0]  line_width_r;
  logic [FR_W-1:0]  frame_rows_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  logic [LW_W-1:0]  eff_width;
  logic [FR_W-1:0]  eff_rows;
  logic             last_col;
  logic             last_row;
  logic             in_acc;
  logic [SUM_W-1:0] sum;
  pos_t             pos;

  logic             s1_v_r;
  logic [SUM_W-1:0] s1_sum_r;
  logic [IDX_W-1:0] s1_idx_r;
  pos_t             s1_pos_r;

  logic [2*PIX_W-1:0] line_mem [MAX_LINE];
  logic [2*PIX_W-1:0] rd_q_r;
  logic [PROD_W-1:0]  prod;
  logic [PIX_W-1:0]   gray;

  logic                  s2_busy;
  logic                  push;
  result_t               result;
  result_t               head;
  logic [SKID_CNT_W-1:0] skid_count;
  logic [SKID_CNT_W:0]   pending;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THR_RESET;
      line_width_r <= LW_RESET;
      frame_rows_r <= FR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold_r  <= cfg_wdata[THR_W-1:0];
        REG_LINE_WIDTH: line_width_r <= cfg_wdata[LW_W-1:0];
        REG_FRAME_ROWS: frame_rows_r <= cfg_wdata[FR_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame geometry and find the row and column ends.
  always_comb begin
    if (line_width_r < LW_W'(MIN_LINE)) begin
      eff_width = LW_W'(MIN_LINE);
    end else if (line_width_r > LW_W'(MAX_LINE)) begin
      eff_width = LW_W'(MAX_LINE);
    end else begin
      eff_width = line_width_r;
    end
    if (frame_rows_r < FR_W'(MIN_ROWS)) begin
      eff_rows = FR_W'(MIN_ROWS);
    end else if (frame_rows_r > FR_W'(MAX_ROWS)) begin
      eff_rows = FR_W'(MAX_ROWS);
    end else begin
      eff_rows = frame_rows_r;
    end
  end

  assign last_col = LW_W'(col_r) >= (eff_width - LW_W'(1));
  assign last_row = FR_W'(row_r) >= (eff_rows - FR_W'(1));

  // Queue room covers every request still in the pipeline.
  assign pending  = (SKID_CNT_W+1)'(skid_count) + (SKID_CNT_W+1)'(s1_v_r)
                  + (SKID_CNT_W+1)'(s2_busy);
  assign in_stall = pending >= (SKID_CNT_W+1)'(SKID_DEPTH);
  assign in_acc   = in_valid & ~in_stall;

  // Weighted color sum; the divide by 100 follows in the next stage.
  assign sum = SUM_W'(in_red) * SUM_W'(W_RED) + SUM_W'(in_green) * SUM_W'(W_GREEN)
             + SUM_W'(in_blue) * SUM_W'(W_BLUE);

  // Interior pixel that this request completes.
  assign pos.has_result    = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign pos.center_row    = row_r - ROW_W'(1);
  assign pos.center_col    = col_r - COL_W'(1);
  assign pos.last_of_frame = last_col & last_row;

  // Raster position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // First pipeline stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sum_r <= sum;
      s1_idx_r <= col_r;
      s1_pos_r <= pos;
    end
  end

  // Line store: upper byte is the previous row, lower byte the row before.
  // Read in the accept cycle, written back in the following cycle with the row shifted down.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q_r <= line_mem[col_r];
    end
    if (s1_v_r) begin
      line_mem[s1_idx_r] <= {gray, rd_q_r[2*PIX_W-1:PIX_W]};
    end
  end

  // Gray value by reciprocal multiply.
  assign prod = PROD_W'(s1_sum_r) * PROD_W'(GRAY_RECIP);
  assign gray = prod[GRAY_SHIFT +: PIX_W];

  lnem_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_v_r),
    .col_top   (rd_q_r[PIX_W-1:0]),
    .col_mid   (rd_q_r[2*PIX_W-1:PIX_W]),
    .col_bot   (gray),
    .pos_in    (s1_pos_r),
    .threshold (threshold_r),
    .busy      (s2_busy),
    .push      (push),
    .result    (result)
  );

  lnem_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .pop_stall (out_stall),
    .pop_valid (out_valid),
    .pop_data  (head),
    .count     (skid_count)
  );

  assign out_center_row    = head.center_row;
  assign out_center_col    = head.center_col;
  assign out_is_edge       = head.is_edge;
  assign out_last_of_frame = head.last_of_frame;

endmodule

[design/lnem_checker.sv]
// Port-level checks for the edge map, attached to the top level by bind.
// Depends on lnem_pkg and luma_neighbourhood_edge_map.
module lnem_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [lnem_pkg::ROW_W-1:0]      out_center_row,
  input logic [lnem_pkg::COL_W-1:0]      out_center_col,
  input logic                            out_is_edge,
  input logic                            out_last_of_frame
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // Results only describe interior pixels.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_center_row != '0) && (out_center_col != '0))
    else $error("result on a border pixel");

  // With nothing pending and no recent request, no result may appear.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3)
      |=> !out_valid)
    else $error("result without a request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_center_row)
      && $stable(out_center_col) && $stable(out_is_edge) && $stable(out_last_of_frame))
    else $error("stalled result changed");

endmodule

bind luma_neighbourhood_edge_map lnem_checker u_lnem_checker (.*);

[test/lnem_edge_checker.sv]
// Checker for the luma neighbourhood edge map: watches the pixel, result and register ports,
// predicts every edge mark and compares it with what the block delivers.
// Depends on lnem_pkg for widths, register indexes and the result layout.
module lnem_edge_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [lnem_pkg::PIX_W-1:0]      in_red,
  input  logic [lnem_pkg::PIX_W-1:0]      in_green,
  input  logic [lnem_pkg::PIX_W-1:0]      in_blue,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [lnem_pkg::ROW_W-1:0]      out_center_row,
  input  logic [lnem_pkg::COL_W-1:0]      out_center_col,
  input  logic                            out_is_edge,
  input  logic                            out_last_of_frame,
  input  logic                            cfg_wr_en,
  input  logic [lnem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lnem_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lnem_pkg::*;

  // Mirror of the register file.
  logic [THR_W-1:0] threshold_q;
  logic [LW_W-1:0]  width_q;
  logic [FR_W-1:0]  rows_q;

  // Mirror of the gray line stores, the 3x3 window and the raster position.
  logic [PIX_W-1:0]                 gray_prev_row [MAX_LINE];
  logic [PIX_W-1:0]                 gray_prev_row2 [MAX_LINE];
  logic [2:0][2:0][PIX_W-1:0]       gray_window;
  int unsigned                      col_at;
  int unsigned                      row_at;

  result_t expected_marks [$];
  int      errors;

  // Register values outside the usable range are clamped when they are used.
  function automatic int unsigned usable_width(input logic [LW_W-1:0] value);
    if (value < MIN_LINE) return MIN_LINE;
    if (value > MAX_LINE) return MAX_LINE;
    return value;
  endfunction

  function automatic int unsigned usable_rows(input logic [FR_W-1:0] value);
    if (value < MIN_ROWS) return MIN_ROWS;
    if (value > MAX_ROWS) return MAX_ROWS;
    return value;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endtask

  // Consume one pixel request: convert to gray, slide the window, update the line stores
  // and queue the mark of the interior pixel that this pixel completes, if any.
  task automatic predict_edge_mark(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                   input logic [PIX_W-1:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    int unsigned luma;
    int unsigned centre;
    int unsigned neighbour;
    int unsigned diff;
    int          i;
    int          j;
    logic        at_last_col;
    logic        at_last_row;
    logic        edge_seen;
    result_t     mark;
    w = usable_width(width_q);
    h = usable_rows(rows_q);
    luma = (W_RED * r + W_GREEN * g + W_BLUE * b) / 100;
    idx = (col_at < MAX_LINE) ? col_at : MAX_LINE - 1;
    at_last_col = (col_at >= w - 1);
    at_last_row = (row_at >= h - 1);

    // Oldest row sits in the top line of the window, the new pixel in the bottom line.
    for (i = 0; i < 3; i++) begin
      gray_window[i][0] = gray_window[i][1];
      gray_window[i][1] = gray_window[i][2];
    end
    gray_window[0][2] = gray_prev_row2[idx];
    gray_window[1][2] = gray_prev_row[idx];
    gray_window[2][2] = PIX_W'(luma);
    gray_prev_row2[idx] = gray_prev_row[idx];
    gray_prev_row[idx] = PIX_W'(luma);

    if (row_at >= 2 && col_at >= 2) begin
      edge_seen = 1'b0;
      centre = gray_window[1][1];
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          if (i != 1 || j != 1) begin
            neighbour = gray_window[i][j];
            diff = (centre > neighbour) ? centre - neighbour : neighbour - centre;
            if (diff > threshold_q) edge_seen = 1'b1;
          end
        end
      end
      mark.center_row = ROW_W'(row_at - 1);
      mark.center_col = COL_W'(col_at - 1);
      mark.is_edge = edge_seen;
      mark.last_of_frame = at_last_col && at_last_row;
      expected_marks.push_back(mark);
    end

    // Advance the raster position; a count at or past the last position wraps.
    if (at_last_col) begin
      col_at = 0;
      row_at = at_last_row ? 0 : row_at + 1;
    end else begin
      col_at = col_at + 1;
    end
  endtask

  // Results are compared before the same edge's pixel is predicted, so a result can never
  // be matched against a mark that its own request has just produced.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      threshold_q = THR_RESET;
      width_q = LW_RESET;
      rows_q = FR_RESET;
      gray_window = '0;
      col_at = 0;
      row_at = 0;
      expected_marks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_marks.size() == 0) begin
          $error("result with nothing expected: row %0d, col %0d", out_center_row,
                 out_center_col);
          errors++;
        end else begin
          want = expected_marks.pop_front();
          check_field("center_row", want.center_row, out_center_row);
          check_field("center_col", want.center_col, out_center_col);
          check_field("is_edge", want.is_edge, out_is_edge);
          check_field("last_of_frame", want.last_of_frame, out_last_of_frame);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_THRESHOLD:  threshold_q = cfg_wdata[THR_W-1:0];
          REG_LINE_WIDTH: width_q = cfg_wdata[LW_W-1:0];
          REG_FRAME_ROWS: rows_q = cfg_wdata[FR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_edge_mark(in_red, in_green, in_blue);
    end
    pending <= expected_marks.size();
    fail_count <= errors;
  end

endmodule

[test/tb_luma_neighbourhood_edge_map.sv]
// Testbench top for the luma neighbourhood edge map: clock, reset, pixel and register
// stimulus with random idling, and the final verdict. Depends on lnem_pkg, the block
// itself and lnem_edge_checker, which does all prediction and comparison.
module tb_luma_neighbourhood_edge_map;
  timeunit 1ns;
  timeprecision 1ps;
  import lnem_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_PIXELS  = 1350;
  localparam int unsigned QUIET_TAIL     = 200;

  // Opening frame: color extremes around a mid-gray center.
  localparam logic [23:0] OPENING_PIXELS [9] = '{
    24'hFFFFFF, 24'h000000, 24'hFF0000,
    24'h00FF00, 24'h808080, 24'h0000FF,
    24'hFFFF00, 24'h010203, 24'hFFFFFF
  };

  typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_BINARY} texture_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_red = '0;
  logic [PIX_W-1:0]      in_green = '0;
  logic [PIX_W-1:0]      in_blue = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_W-1:0]      out_center_row;
  logic [COL_W-1:0]      out_center_col;
  logic                  out_is_edge;
  logic                  out_last_of_frame;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;

  // Stimulus state: raster position as the block should see it and idling controls.
  int unsigned pos_col;
  int unsigned pos_row;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned pixels_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned smooth_level;
  logic        quiet = 1'b0;
  texture_t    texture = TEX_NOISE;

  always #2 clk = ~clk;

  luma_neighbourhood_edge_map DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_center_row(out_center_row), .out_center_col(out_center_col),
    .out_is_edge(out_is_edge), .out_last_of_frame(out_last_of_frame),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  lnem_edge_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_center_row(out_center_row), .out_center_col(out_center_col),
    .out_is_edge(out_is_edge), .out_last_of_frame(out_last_of_frame),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side backpressure: random stall bursts, none in the quiet tail.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned usable_width(input logic [CFG_DATA_W-1:0] data);
    int unsigned value;
    value = data[LW_W-1:0];
    if (value < MIN_LINE) return MIN_LINE;
    if (value > MAX_LINE) return MAX_LINE;
    return value;
  endfunction

  function automatic int unsigned usable_rows(input logic [CFG_DATA_W-1:0] data);
    int unsigned value;
    value = data[FR_W-1:0];
    if (value < MIN_ROWS) return MIN_ROWS;
    if (value > MAX_ROWS) return MAX_ROWS;
    return value;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return CFG_DATA_W'(255);
    if (roll <= 3) return CFG_DATA_W'($urandom_range(0, 8191));
    return CFG_DATA_W'($urandom_range(0, 40));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return CFG_DATA_W'($urandom_range(0, 2));
    if (roll == 1) return CFG_DATA_W'($urandom_range(11, 40));
    return CFG_DATA_W'($urandom_range(3, 10));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rows();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return CFG_DATA_W'($urandom_range(0, 2));
    if (roll == 1) return CFG_DATA_W'($urandom_range(9, 20));
    return CFG_DATA_W'($urandom_range(3, 8));
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] jitter(input int unsigned level);
    int value;
    value = int'(level) + int'($urandom_range(0, 12)) - 6;
    if (value < 0) value = 0;
    if (value > 255) value = 255;
    return PIX_W'(value);
  endfunction

  // Write all three registers on consecutive edges; only called while the block is idle.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_data,
                              input logic [CFG_DATA_W-1:0] lw_data,
                              input logic [CFG_DATA_W-1:0] fr_data);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= thr_data;
    @(posedge clk);
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= lw_data;
    @(posedge clk);
    cfg_index <= REG_FRAME_ROWS;
    cfg_wdata <= fr_data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_w = usable_width(lw_data);
    cur_h = usable_rows(fr_data);
  endtask

  // Present one pixel request, with an optional idle burst first, and hold it until taken.
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    if (pos_col >= cur_w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= cur_h - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic send_textured_pixel();
    case (texture)
      TEX_SMOOTH: begin
        if ($urandom_range(0, 31) == 0) smooth_level = $urandom_range(0, 255);
        send_pixel(jitter(smooth_level), jitter(smooth_level), jitter(smooth_level));
      end
      TEX_BINARY: begin
        send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                   $urandom_range(0, 1) ? 8'hFF : 8'h00);
      end
      default: begin
        send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                   PIX_W'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty fully.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic finish_frame();
    while (pos_col != 0 || pos_row != 0) send_textured_pixel();
  endtask

  initial begin
    int unsigned start;
    int unsigned total;
    int unsigned split;
    int          i;
    logic        mid_change;
    logic [PIX_W-1:0] level;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: color extremes with a zero threshold, then a 0/255 checkerboard where the
    // full gray swing equals the threshold (no edge) and then exceeds it by one.
    gap_pct = 20;
    stall_pct = 20;
    program_regs('0, CFG_DATA_W'(3), CFG_DATA_W'(3));
    for (i = 0; i < 9; i++) begin
      send_pixel(OPENING_PIXELS[i][23:16], OPENING_PIXELS[i][15:8], OPENING_PIXELS[i][7:0]);
    end
    drain();
    program_regs(CFG_DATA_W'(255), CFG_DATA_W'(3), CFG_DATA_W'(3));
    for (i = 0; i < 9; i++) begin
      level = (i % 2 == 0) ? 8'hFF : 8'h00;
      send_pixel(level, level, level);
    end
    drain();
    program_regs(CFG_DATA_W'(254), CFG_DATA_W'(3), CFG_DATA_W'(3));
    for (i = 0; i < 9; i++) begin
      level = (i % 2 == 0) ? 8'h00 : 8'hFF;
      send_pixel(level, level, level);
    end
    drain();

    // Small frames from odd register data: unused high data bits of the threshold and
    // width writes are ignored, and widths and row counts below the range saturate.
    gap_pct = 10;
    stall_pct = 10;
    texture = TEX_SMOOTH;
    smooth_level = 128;
    program_regs(CFG_DATA_W'('h1F05), CFG_DATA_W'('h1805), '0);
    repeat (cur_w * cur_h) send_textured_pixel();
    drain();
    program_regs(CFG_DATA_W'(8), CFG_DATA_W'(1), CFG_DATA_W'(4));
    repeat (cur_w * cur_h) send_textured_pixel();
    drain();

    // Random phases of small frames; some change registers part way through a frame,
    // shrinking the geometry so that the stores never serve an unwritten column.
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      quiet = (pixels_sent - start >= RANDOM_PIXELS - QUIET_TAIL);
      gap_pct = pick_idle_pct();
      stall_pct = pick_idle_pct();
      texture = texture_t'($urandom_range(0, 2));
      smooth_level = $urandom_range(0, 255);
      program_regs(pick_threshold(), pick_width(), pick_rows());
      total = $urandom_range(1, 2) * cur_w * cur_h;
      mid_change = ($urandom_range(0, 2) == 0);
      split = mid_change ? $urandom_range(1, total - 1) : total;
      repeat (split) send_textured_pixel();
      if (mid_change) begin
        drain();
        program_regs(pick_threshold(), CFG_DATA_W'($urandom_range(0, cur_w)),
                     CFG_DATA_W'($urandom_range(0, cur_h)));
      end
      finish_frame();
      drain();
    end

    @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lnem_pkg.sv
design/lnem_window.sv
design/lnem_skid.sv
design/luma_neighbourhood_edge_map.sv
design/lnem_checker.sv
test/lnem_edge_checker.sv
test/tb_luma_neighbourhood_edge_map.sv
